[rtl/lcm_pkg.sv]
// Shared types and constants for the min-hull tree with rollback.
`default_nettype none
package lcm_pkg;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 10;
    localparam int X_W     = 32;
    localparam int ICPT_W  = 48;
    localparam int SLOPE_W = 32;
    localparam int TGT_W   = 13;
    localparam int MIN_W   = 64;
    localparam int CNT_W   = 13;
    localparam int NODE_IW = 64;
    localparam int LINE_W  = NODE_IW + SLOPE_W;
    localparam int MAC_W   = 66;

    typedef logic [KIND_W-1:0]         t_kind;
    typedef logic [POS_W-1:0]          t_pos;
    typedef logic signed [X_W-1:0]     t_x;
    typedef logic signed [ICPT_W-1:0]  t_icpt;
    typedef logic signed [SLOPE_W-1:0] t_slope;
    typedef logic [TGT_W-1:0]          t_tgt;
    typedef logic signed [MIN_W-1:0]   t_min;
    typedef logic [CNT_W-1:0]          t_cnt;

    typedef struct packed {
        logic signed [NODE_IW-1:0] icpt;
        logic signed [SLOPE_W-1:0] slope;
    } t_line;

    localparam t_kind KIND_CLEAR = 3'd0;
    localparam t_kind KIND_LOAD  = 3'd1;
    localparam t_kind KIND_ADD   = 3'd2;
    localparam t_kind KIND_QUERY = 3'd3;
    localparam t_kind KIND_UNDO  = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    localparam logic signed [NODE_IW-1:0] BIG_VALUE = 64'sd1000000000000000000;
endpackage
`default_nettype wire

[rtl/lcm_if.sv]
// Request and response channel interfaces.
`default_nettype none
interface lcm_req_if;
    import lcm_pkg::*;
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_pos   position;
    t_x     x_value;
    t_icpt  intercept;
    t_slope slope;
    t_tgt   undo_target;
    modport source(output valid, kind, position, x_value, intercept, slope, undo_target,
                   input ready);
    modport sink(input valid, kind, position, x_value, intercept, slope, undo_target,
                 output ready);
endinterface

interface lcm_rsp_if;
    import lcm_pkg::*;
    logic valid;
    logic ready;
    t_min min_value;
    t_cnt log_count;
    logic status;
    modport source(output valid, min_value, log_count, status, input ready);
    modport sink(input valid, min_value, log_count, status, output ready);
endinterface
`default_nettype wire

[rtl/lcm_ram.sv]
// Simple dual-port synchronous RAM, registered read.
`default_nettype none
module lcm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/lcm_mac.sv]
// Registered multiply followed by add: o_sum = x*m + d.
`default_nettype none
module lcm_mac (
    input  wire logic                            i_clk,
    input  wire logic signed [lcm_pkg::X_W-1:0]  i_x,
    input  wire logic signed [lcm_pkg::X_W:0]    i_m,
    input  wire logic signed [lcm_pkg::MAC_W-1:0] i_d,
    output logic      signed [lcm_pkg::MAC_W-1:0] o_sum
);
    import lcm_pkg::*;
    logic signed [2*X_W:0]   w_prod;
    logic signed [2*X_W:0]   r_prod;
    logic signed [MAC_W-1:0] r_d;

    assign w_prod = i_x * i_m;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_d    <= i_d;
    end

    assign o_sum = r_prod + r_d;
endmodule
`default_nettype wire

[rtl/li_chao_min_hull_with_undo_core.sv]
// Top level: min-of-lines tree over a sorted point table, with undo log.
//
//  channel   dir  modport  payload
//  i_req     in   sink     kind, position, x_value, intercept, slope, undo_target
//  o_rsp     out  source   min_value, log_count, status
//
// Add, per tree level: node/point read, then multiply and compare at mid, lo and hi as
// needed; one shared multiplier. Query: point read, then multiply and compare per node
// on the path to the root. Undo: log read and node write per restored log entry.
// Clear and reset: sweep of all 2^LOG_POSITIONS node RAM entries, no requests taken.
// A finished response waits in the output register; the next request is taken meanwhile.
`default_nettype none
module li_chao_min_hull_with_undo_core #(
    parameter int LOG_POSITIONS = 10,
    parameter int LOG_DEPTH     = 4096
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lcm_req_if.sink   i_req,
    lcm_rsp_if.source o_rsp
);
    import lcm_pkg::*;

    localparam int LP  = LOG_POSITIONS;
    localparam int TS  = 1 << LP;
    localparam int FW  = $clog2(LOG_DEPTH + 1);
    localparam int LAW = $clog2(LOG_DEPTH);
    localparam int LW  = LP + LINE_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_A_RD     = 4'd2;
    localparam logic [3:0] S_A_MUL    = 4'd3;
    localparam logic [3:0] S_A_CMP    = 4'd4;
    localparam logic [3:0] S_A_LO_MUL = 4'd5;
    localparam logic [3:0] S_A_LO_CMP = 4'd6;
    localparam logic [3:0] S_A_HI_MUL = 4'd7;
    localparam logic [3:0] S_A_HI_CMP = 4'd8;
    localparam logic [3:0] S_Q_RD     = 4'd9;
    localparam logic [3:0] S_Q_MUL    = 4'd10;
    localparam logic [3:0] S_Q_CMP    = 4'd11;
    localparam logic [3:0] S_U_RD     = 4'd12;
    localparam logic [3:0] S_U_WR     = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0]                r_state;
    logic [FW-1:0]             r_fill;
    logic [LP-1:0]             r_sweep;
    logic                      r_clr_item;
    logic                      r_ovalid;
    logic [LP-1:0]             r_node;
    logic [LP-1:0]             r_lo;
    logic [LP-1:0]             r_hi;
    logic [LP-1:0]             r_pos;
    logic signed [NODE_IW-1:0] r_a;
    logic signed [SLOPE_W-1:0] r_b;
    logic signed [NODE_IW-1:0] r_ca;
    logic signed [SLOPE_W-1:0] r_cb;
    logic signed [X_W-1:0]     r_x;
    logic                      r_first;
    logic signed [MIN_W-1:0]   r_best;
    logic                      r_status;
    t_tgt                      r_target;
    t_min                      r_omin;
    t_cnt                      r_ocnt;
    logic                      r_ostat;

    logic          w_accept;
    logic [31:0]   w_pos32;
    logic [31:0]   w_j32;
    logic [4:0]    w_z;
    logic [31:0]   w_qn32;
    logic [LP-1:0] w_qnode;
    logic [LP-1:0] w_pos_idx;
    logic          w_load_ok;
    logic          w_query_ok;
    logic          w_refuse;
    logic [LP:0]   w_mid_sum;
    logic [LP-1:0] w_mid;
    logic [LP-1:0] w_qnext;
    logic          w_out_free;

    logic              w_node_we;
    logic [LP-1:0]     w_node_waddr;
    logic [LINE_W-1:0] w_node_wdata;
    logic [LP-1:0]     w_node_raddr;
    logic [LINE_W-1:0] w_node_rdata;
    t_line             w_node_rd;
    logic              w_pt_we;
    logic [LP-1:0]     w_pt_raddr;
    logic [X_W-1:0]    w_pt_rdata;
    logic              w_log_we;
    logic [LW-1:0]     w_log_wdata;
    logic [LW-1:0]     w_log_rdata;
    logic [LAW-1:0]    w_log_waddr;
    logic [LAW-1:0]    w_log_raddr;

    logic signed [X_W-1:0]   w_mac_x;
    logic signed [X_W:0]     w_mac_m;
    logic signed [MAC_W-1:0] w_mac_d;
    logic signed [MAC_W-1:0] w_sum;
    logic                    w_below;
    logic signed [MIN_W-1:0] w_v;

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_pos32    = 32'(i_req.position);
    assign w_pos_idx  = w_pos32[LP-1:0];
    assign w_load_ok  = w_pos32 < 32'(TS);
    assign w_query_ok = w_pos32 <= 32'(TS - 2);
    assign w_refuse   = (32'(LOG_DEPTH) - 32'(r_fill)) < 32'(LP);
    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_mid_sum[LP:1];
    assign w_qnext    = r_node >> 1;
    assign w_out_free = !r_ovalid || o_rsp.ready;

    // node of an in-order position: strip trailing zeros of pos+1
    always_comb begin
        w_j32 = w_pos32 + 32'd1;
        w_z   = '0;
        for (int i = LP - 1; i >= 0; i--) begin
            if (w_j32[i]) begin
                w_z = 5'(i);
            end
        end
        w_qn32  = ((32'd1 << (LP - 32'(w_z))) | (w_j32 >> w_z)) >> 1;
        w_qnode = w_qn32[LP-1:0];
    end

    assign w_node_rd = t_line'(w_node_rdata);
    assign w_v       = w_sum[MIN_W-1:0];
    assign w_below   = w_sum[MAC_W-1];

    // multiplier operands: add compares x*(b-cb) + (a-ca) < 0; query forms cb*x + ca
    always_comb begin
        w_mac_x = $signed(w_pt_rdata);
        w_mac_m = $signed({r_b[SLOPE_W-1], r_b}) - $signed({r_cb[SLOPE_W-1], r_cb});
        w_mac_d = $signed({{2{r_a[NODE_IW-1]}}, r_a}) - $signed({{2{r_ca[NODE_IW-1]}}, r_ca});
        case (r_state)
            S_A_MUL: begin
                w_mac_m = $signed({r_b[SLOPE_W-1], r_b})
                        - $signed({w_node_rd.slope[SLOPE_W-1], w_node_rd.slope});
                w_mac_d = $signed({{2{r_a[NODE_IW-1]}}, r_a})
                        - $signed({{2{w_node_rd.icpt[NODE_IW-1]}}, w_node_rd.icpt});
            end
            S_Q_MUL: begin
                if (!r_first) begin
                    w_mac_x = r_x;
                end
                w_mac_m = $signed({w_node_rd.slope[SLOPE_W-1], w_node_rd.slope});
                w_mac_d = $signed({{2{w_node_rd.icpt[NODE_IW-1]}}, w_node_rd.icpt});
            end
            default: begin
            end
        endcase
    end

    // memory address and write control
    always_comb begin
        w_node_raddr = r_node;
        w_pt_raddr   = w_mid;
        w_node_we    = 1'b0;
        w_node_waddr = r_node;
        w_node_wdata = {r_a, r_b};
        w_log_we     = 1'b0;
        case (r_state)
            S_CLR: begin
                w_node_we    = 1'b1;
                w_node_waddr = r_sweep;
                w_node_wdata = {BIG_VALUE, {SLOPE_W{1'b0}}};
            end
            S_A_CMP: begin
                w_pt_raddr = r_lo;
                w_node_we  = w_below;
                w_log_we   = w_below && (32'(r_fill) < 32'(LOG_DEPTH));
            end
            S_A_LO_CMP: w_pt_raddr = r_hi;
            S_Q_RD:     w_pt_raddr = r_pos;
            S_Q_CMP:    w_node_raddr = w_qnext;
            S_U_WR: begin
                w_node_we    = 1'b1;
                w_node_waddr = w_log_rdata[LW-1:LINE_W];
                w_node_wdata = w_log_rdata[LINE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_pt_we     = w_accept && (i_req.kind == KIND_LOAD) && w_load_ok;
    assign w_log_wdata = {r_node, r_ca, r_cb};
    assign w_log_waddr = LAW'(r_fill);
    assign w_log_raddr = LAW'(r_fill - 1'b1);

    lcm_ram #(.WIDTH(LINE_W), .DEPTH(TS)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we),
        .i_waddr (w_node_waddr),
        .i_wdata (w_node_wdata),
        .i_raddr (w_node_raddr),
        .o_rdata (w_node_rdata)
    );

    lcm_ram #(.WIDTH(X_W), .DEPTH(TS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (w_pos_idx),
        .i_wdata (i_req.x_value),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    lcm_ram #(.WIDTH(LW), .DEPTH(LOG_DEPTH)) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (w_log_we),
        .i_waddr (w_log_waddr),
        .i_wdata (w_log_wdata),
        .i_raddr (w_log_raddr),
        .o_rdata (w_log_rdata)
    );

    lcm_mac u_mac (
        .i_clk (i_clk),
        .i_x   (w_mac_x),
        .i_m   (w_mac_m),
        .i_d   (w_mac_d),
        .o_sum (w_sum)
    );

    // response valid: set when a result is loaded, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_fill     <= '0;
            r_sweep    <= '0;
            r_clr_item <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_best   <= (i_req.kind == KIND_QUERY) ? BIG_VALUE : '0;
                        r_status <= (i_req.kind == KIND_ADD && w_refuse) ? STATUS_REFUSED
                                                                         : STATUS_OK;
                        case (i_req.kind)
                            KIND_CLEAR: begin
                                r_fill     <= '0;
                                r_sweep    <= '0;
                                r_clr_item <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            KIND_ADD: begin
                                if (w_refuse) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_a     <= NODE_IW'(i_req.intercept);
                                    r_b     <= i_req.slope;
                                    r_node  <= LP'(1);
                                    r_lo    <= '0;
                                    r_hi    <= LP'(TS - 2);
                                    r_state <= S_A_RD;
                                end
                            end
                            KIND_QUERY: begin
                                if (w_query_ok) begin
                                    r_node  <= w_qnode;
                                    r_pos   <= w_pos_idx;
                                    r_first <= 1'b1;
                                    r_state <= S_Q_RD;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            KIND_UNDO: begin
                                r_target <= i_req.undo_target;
                                r_state  <= (32'(i_req.undo_target) < 32'(r_fill)) ? S_U_RD
                                                                                   : S_OUT;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (&r_sweep) begin
                        r_clr_item <= 1'b0;
                        r_state    <= r_clr_item ? S_OUT : S_IDLE;
                    end
                end
                S_A_RD: r_state <= S_A_MUL;
                S_A_MUL: begin
                    r_ca    <= w_node_rd.icpt;
                    r_cb    <= w_node_rd.slope;
                    r_state <= S_A_CMP;
                end
                S_A_CMP: begin
                    if (w_below) begin
                        if (w_log_we) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_a  <= r_ca;
                        r_b  <= r_cb;
                        r_ca <= r_a;
                        r_cb <= r_b;
                    end
                    if (r_lo == r_hi || w_mid == r_lo) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_A_LO_MUL;
                    end
                end
                S_A_LO_MUL: r_state <= S_A_LO_CMP;
                S_A_LO_CMP: begin
                    if (w_below) begin
                        r_node  <= LP'({r_node, 1'b0});
                        r_hi    <= w_mid - 1'b1;
                        r_state <= S_A_RD;
                    end else begin
                        r_state <= S_A_HI_MUL;
                    end
                end
                S_A_HI_MUL: r_state <= S_A_HI_CMP;
                S_A_HI_CMP: begin
                    if (w_below) begin
                        r_node  <= LP'({r_node, 1'b1});
                        r_lo    <= w_mid + 1'b1;
                        r_state <= S_A_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_Q_RD: r_state <= S_Q_MUL;
                S_Q_MUL: begin
                    if (r_first) begin
                        r_x <= $signed(w_pt_rdata);
                    end
                    r_first <= 1'b0;
                    r_state <= S_Q_CMP;
                end
                S_Q_CMP: begin
                    if (w_v < r_best) begin
                        r_best <= w_v;
                    end
                    r_node  <= w_qnext;
                    r_state <= (w_qnext == '0) ? S_OUT : S_Q_MUL;
                end
                S_U_RD: r_state <= S_U_WR;
                S_U_WR: begin
                    r_fill  <= r_fill - 1'b1;
                    r_state <= ((32'(r_fill) - 32'd1) > 32'(r_target)) ? S_U_RD : S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_omin   <= r_best;
                        r_ocnt   <= CNT_W'(r_fill);
                        r_ostat  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.min_value = r_omin;
    assign o_rsp.log_count = r_ocnt;
    assign o_rsp.status    = r_ostat;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(LOG_DEPTH))
        else $error("log count above log depth");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == KIND_CLEAR) |=> (r_state == S_CLR && r_fill == '0))
        else $error("clear request did not start a sweep");

    a_refused_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == KIND_ADD && w_refuse) |=> (r_fill == $past(r_fill)))
        else $error("refused add changed the log");

    a_undo_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U_WR) |=> (r_fill == FW'($past(r_fill) - 1'b1)))
        else $error("undo did not retire one log entry");
endmodule
`default_nettype wire
